FILE: hw/rtl/idps_pkg.sv
package idps_pkg;

    // Fixed field widths of the stream and register interface.
    localparam int ELEM_W        = 8;
    localparam int ELEM_SLOTS    = 8;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int SCORE_W       = 24;
    localparam int ROW_NUM_W     = 25;
    localparam int VLEN_W        = 9;
    localparam int FIRST_ROW_W   = 24;
    localparam int ROW_COUNT_W   = 25;
    localparam int CFG_DATA_W    = 25;
    localparam int CFG_INDEX_W   = 2;
    localparam int IN_DATA_W     = ELEM_SLOTS * ELEM_W;
    localparam int OUT_DATA_W    = 56;

    // Register reset values and limits.
    localparam int DEF_MAX_DIMENSIONS = 256;
    localparam int DEF_LANES          = 8;
    localparam logic [VLEN_W-1:0]      VLEN_RESET      = 9'd256;
    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 25'd1;
    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_MAX   = 25'd16777216;

    // Beat kind carried on tuser.
    typedef enum logic {
        MODE_QUERY = 1'b0,
        MODE_ROW   = 1'b1
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VECTOR_LENGTH = 2'd0,
        REG_FIRST_ROW     = 2'd1,
        REG_ROW_COUNT     = 2'd2
    } cfg_index_t;

    // Control that travels down the pipeline with each beat.
    typedef struct packed {
        logic row;
        logic last_chunk;
    } stage_ctrl_t;

endpackage

FILE: hw/rtl/idps_lane.sv
module idps_lane #(
    parameter int ADDR_W = 5
) (
    input  logic                                clk,
    input  logic                                load1,
    input  logic                                load2,
    input  logic                                wr_en,
    input  logic [ADDR_W-1:0]                   addr,
    input  logic signed [idps_pkg::ELEM_W-1:0]  elem,
    input  logic                                lane_en,
    output logic signed [idps_pkg::PROD_W-1:0]  product
);
    import idps_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic signed [ELEM_W-1:0] mem [DEPTH];
    logic signed [ELEM_W-1:0] query_reg;
    logic signed [ELEM_W-1:0] elem_reg;
    logic                     lane_en_reg;
    logic signed [PROD_W-1:0] product_reg;

    // Query slice of this lane: written on query beats, read into a register on every accepted beat.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= elem;
        end
        if (load1)
        begin
            query_reg   <= mem[addr];
            elem_reg    <= elem;
            lane_en_reg <= lane_en;
        end
    end

    // Multiply stage; lanes past the vector end contribute zero.
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            product_reg <= lane_en_reg ? PROD_W'(query_reg * elem_reg) : '0;
        end
    end

    assign product = product_reg;

endmodule

FILE: hw/rtl/idps_seq.sv
module idps_seq #(
    parameter int MAX_DIMENSIONS = idps_pkg::DEF_MAX_DIMENSIONS,
    parameter int LANES          = idps_pkg::DEF_LANES,
    parameter int ADDR_W         = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [idps_pkg::VLEN_W-1:0]   vector_length,
    output logic [ADDR_W-1:0]             chunk,
    output logic [LANES-1:0]              lane_en,
    output logic                          last_chunk
);
    import idps_pkg::*;

    localparam int POS_W = $clog2(MAX_DIMENSIONS);
    localparam int CMP_W = ((POS_W > VLEN_W) ? POS_W : VLEN_W) + 1;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [ADDR_W-1:0] chunk_reg;
    logic [ADDR_W-1:0] chunk_next;
    logic [CMP_W-1:0]  eff_len;
    logic [CMP_W-1:0]  pos_ext;

    // Effective length: zero counts as one, clamp to the store size.
    always_comb
    begin
        if (vector_length == '0)
        begin
            eff_len = CMP_W'(1);
        end
        else if (CMP_W'(vector_length) > CMP_W'(MAX_DIMENSIONS))
        begin
            eff_len = CMP_W'(MAX_DIMENSIONS);
        end
        else
        begin
            eff_len = CMP_W'(vector_length);
        end
    end

    assign pos_ext    = CMP_W'(pos_reg);
    assign last_chunk = (pos_ext + CMP_W'(LANES)) >= eff_len;

    // A lane is live while its element position is inside the vector.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_en[i] = (pos_ext + CMP_W'(i)) < eff_len;
        end
    end

    // Position and chunk address advance by one chunk per accepted beat and return to zero after the last chunk.
    always_comb
    begin
        pos_next   = pos_reg;
        chunk_next = chunk_reg;
        if (accept)
        begin
            if (last_chunk)
            begin
                pos_next   = '0;
                chunk_next = '0;
            end
            else
            begin
                pos_next   = POS_W'(pos_ext + CMP_W'(LANES));
                chunk_next = chunk_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            chunk_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            chunk_reg <= chunk_next;
        end
    end

    assign chunk = chunk_reg;

endmodule

FILE: hw/rtl/idps_merge.sv
module idps_merge #(
    parameter int LANES = idps_pkg::DEF_LANES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s2_valid,
    input  idps_pkg::stage_ctrl_t                s2_ctrl,
    input  logic signed [idps_pkg::PROD_W-1:0]   products [LANES],
    input  logic [idps_pkg::FIRST_ROW_W-1:0]     first_row,
    input  logic [idps_pkg::ROW_COUNT_W-1:0]     row_count,
    output logic                                 s2_go,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [idps_pkg::SCORE_W-1:0]  score,
    output logic [idps_pkg::ROW_NUM_W-1:0]       row_number,
    output logic                                 last_row
);
    import idps_pkg::*;

    logic signed [SCORE_W-1:0]   running_sum_reg;
    logic [ROW_COUNT_W-1:0]      rows_scored_reg;
    logic                        out_valid_reg;
    logic signed [SCORE_W-1:0]   score_reg;
    logic [ROW_NUM_W-1:0]        row_number_reg;
    logic                        last_row_reg;
    logic signed [SCORE_W-1:0]   sum_total;
    logic [ROW_COUNT_W-1:0]      eff_rows;
    logic                        is_last;
    logic                        emit;
    logic                        fire;

    // Add the lane products onto the running sum (wraps in 24 bits).
    always_comb
    begin
        sum_total = running_sum_reg;
        for (int i = 0; i < LANES; i++)
        begin
            sum_total = sum_total + SCORE_W'(products[i]);
        end
    end

    // Effective row count: zero counts as one, clamp to the maximum.
    always_comb
    begin
        if (row_count == '0)
        begin
            eff_rows = ROW_COUNT_W'(1);
        end
        else if (row_count > ROW_COUNT_MAX)
        begin
            eff_rows = ROW_COUNT_MAX;
        end
        else
        begin
            eff_rows = row_count;
        end
    end

    assign is_last = ({1'b0, rows_scored_reg} + (ROW_COUNT_W+1)'(1))
                     >= {1'b0, eff_rows};

    // Only a beat that ends a row needs room in the output register.
    assign emit  = s2_ctrl.row && s2_ctrl.last_chunk;
    assign s2_go = !s2_valid || !emit || !out_valid_reg || out_ready;
    assign fire  = s2_valid && s2_go;

    // Accumulator and row counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            rows_scored_reg <= '0;
        end
        else if (fire && s2_ctrl.row)
        begin
            if (s2_ctrl.last_chunk)
            begin
                running_sum_reg <= '0;
                rows_scored_reg <= is_last ? '0 : rows_scored_reg + ROW_COUNT_W'(1);
            end
            else
            begin
                running_sum_reg <= sum_total;
            end
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            score_reg      <= sum_total;
            row_number_reg <= ROW_NUM_W'(first_row) + rows_scored_reg;
            last_row_reg   <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign score      = score_reg;
    assign row_number = row_number_reg;
    assign last_row   = last_row_reg;

endmodule

FILE: hw/rtl/int8_dot_product_scan_unit.sv
// A row's final beat passes the stage-1, stage-2 and output registers before its result shows on m_tvalid.
// Throughput: one beat per cycle while s_tready is high; query slices use one address per beat.
// The output register holds a result while beats that end no row keep flowing in.
// Reset (rst_n, async, active low) clears position, sums, counters and valid flags and
// restores the registers; the query store is not cleared and must be loaded before rows.
module int8_dot_product_scan_unit #(
    parameter int MAX_DIMENSIONS = idps_pkg::DEF_MAX_DIMENSIONS,
    parameter int LANES          = idps_pkg::DEF_LANES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [idps_pkg::IN_DATA_W-1:0]      s_tdata,   // elem0..elem7, 8 bits each
    input  logic                                s_tuser,   // mode
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [idps_pkg::OUT_DATA_W-1:0]     m_tdata,   // score[23:0], row_number[48:24]
    output logic                                m_tlast,   // last_row
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [idps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [idps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import idps_pkg::*;

    localparam int ROWS   = (MAX_DIMENSIONS + LANES - 1) / LANES;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [VLEN_W-1:0]         vector_length_reg;
    logic [FIRST_ROW_W-1:0]    first_row_reg;
    logic [ROW_COUNT_W-1:0]    row_count_reg;

    logic                      s1_valid_reg;
    stage_ctrl_t               s1_ctrl_reg;
    logic                      s2_valid_reg;
    stage_ctrl_t               s2_ctrl_reg;

    logic                      accept;
    logic                      s1_free;
    logic                      s2_free;
    logic                      load2;
    logic                      s2_go;
    mode_t                     mode;
    logic [ADDR_W-1:0]         chunk;
    logic [LANES-1:0]          lane_en;
    logic                      last_chunk;
    logic signed [PROD_W-1:0]  products [LANES];
    logic signed [SCORE_W-1:0] score;
    logic [ROW_NUM_W-1:0]      row_number;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= VLEN_RESET;
            first_row_reg     <= '0;
            row_count_reg     <= ROW_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VECTOR_LENGTH: vector_length_reg <= cfg_data[VLEN_W-1:0];
                REG_FIRST_ROW:     first_row_reg     <= cfg_data[FIRST_ROW_W-1:0];
                REG_ROW_COUNT:     row_count_reg     <= cfg_data[ROW_COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Pipeline flow: a stage moves on when the one after it has room.
    assign mode     = mode_t'(s_tuser);
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;
    assign accept   = s_tvalid && s1_free;
    assign load2    = s1_valid_reg && s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg.row        <= (mode == MODE_ROW);
            s1_ctrl_reg.last_chunk <= last_chunk;
        end
        if (load2)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    // Element position and chunk addressing.
    idps_seq #(
        .MAX_DIMENSIONS (MAX_DIMENSIONS),
        .LANES          (LANES),
        .ADDR_W         (ADDR_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .vector_length (vector_length_reg),
        .chunk         (chunk),
        .lane_en       (lane_en),
        .last_chunk    (last_chunk)
    );

    // One query slice and multiplier per lane.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        idps_lane #(
            .ADDR_W (ADDR_W)
        ) u_lane (
            .clk     (clk),
            .load1   (accept),
            .load2   (load2),
            .wr_en   (accept && (mode == MODE_QUERY) && lane_en[g]),
            .addr    (chunk),
            .elem    (s_tdata[g*ELEM_W +: ELEM_W]),
            .lane_en (lane_en[g]),
            .product (products[g])
        );
    end

    // Lane sum, row bookkeeping and output register.
    idps_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .s2_valid   (s2_valid_reg),
        .s2_ctrl    (s2_ctrl_reg),
        .products   (products),
        .first_row  (first_row_reg),
        .row_count  (row_count_reg),
        .s2_go      (s2_go),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .score      (score),
        .row_number (row_number),
        .last_row   (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W - SCORE_W - ROW_NUM_W){1'b0}}, row_number, score};

endmodule
